>>> rtl/cssds_pkg.sv
`default_nettype none

package cssds_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DECL  = 2'd1;
   localparam logic [1:0] KIND_BLOCK = 2'd2;

   // quote tracking
   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   // comment tracking
   localparam logic [1:0] CMT_NONE = 2'd0;
   localparam logic [1:0] CMT_BODY = 2'd1;
   localparam logic [1:0] CMT_STAR = 2'd2;

   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;

   // entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // what the back has to do for one input word, in this order:
   // flush held blanks, slash, the byte, end of declaration, end of block,
   // then store the byte as a held blank
   typedef struct packed {
      logic [7:0] byte_val;
      logic       emit_slash;
      logic       emit_byte;
      logic       decl;
      logic       block;
      logic       ovf;
      logic       wr;
   } cmd_flags_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_CR) || (c == CH_FF);
   endfunction

endpackage

`default_nettype wire

>>> rtl/cssds_req_if.sv
`default_nettype none

interface cssds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source(output valid, output in_byte, output last_byte, input ready);
   modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/cssds_rsp_if.sv
`default_nettype none

interface cssds_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       overflow;
   logic       run_last;

   modport source(output valid, output out_byte, output kind, output overflow,
                  output run_last, input ready);
   modport sink(input valid, input out_byte, input kind, input overflow,
                input run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/cssds_front.sv
`default_nettype none

module cssds_front #(
   parameter int BLANK_DEPTH = 16,
   parameter int DEPTH_BITS  = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cssds_req_if.sink                   req_ch,
   input  wire logic                   q_ready,
   output logic                        q_push,
   output cssds_pkg::cmd_flags_type    q_flags,
   output logic [$clog2(BLANK_DEPTH + 1)-1:0]                      q_flush,
   output logic [((BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1)-1:0] q_widx
);

   localparam int CW = $clog2(BLANK_DEPTH + 1);
   localparam int AW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

   logic [1:0]            quote_ff, quote_in;
   logic                  esc_ff, esc_in;
   logic [1:0]            cmt_ff, cmt_in;
   logic                  slash_ff, slash_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  seg_ff, seg_in;
   logic [CW-1:0]         bcnt_ff, bcnt_in;
   logic                  ovf_ff, ovf_in;

   logic       keep_slash, keep_c, end_seg, depth_sat, plain;
   logic [7:0] c;
   logic       accept;

   assign c      = req_ch.in_byte;
   assign accept = req_ch.valid && q_ready;
   assign req_ch.ready = q_ready;

   always_comb begin
      quote_in   = quote_ff;
      esc_in     = esc_ff;
      cmt_in     = cmt_ff;
      slash_in   = slash_ff;
      depth_in   = depth_ff;
      keep_slash = 1'b0;
      keep_c     = 1'b0;
      end_seg    = 1'b0;
      depth_sat  = 1'b0;
      plain      = 1'b0;

      if (cmt_ff != cssds_pkg::CMT_NONE) begin
         if (c == cssds_pkg::CH_STAR) begin
            cmt_in = cssds_pkg::CMT_STAR;
         end else if (cmt_ff == cssds_pkg::CMT_STAR && c == cssds_pkg::CH_SLASH) begin
            cmt_in = cssds_pkg::CMT_NONE;
         end else begin
            cmt_in = cssds_pkg::CMT_BODY;
         end
      end else if (quote_ff != cssds_pkg::QUOTE_NONE) begin
         keep_c = 1'b1;
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (c == cssds_pkg::CH_BSLASH) begin
            esc_in = 1'b1;
         end else if ((quote_ff == cssds_pkg::QUOTE_SINGLE && c == cssds_pkg::CH_APOS) ||
                      (quote_ff == cssds_pkg::QUOTE_DOUBLE && c == cssds_pkg::CH_QUOTE)) begin
            quote_in = cssds_pkg::QUOTE_NONE;
         end
      end else begin
         plain = 1'b1;
         if (slash_ff) begin
            slash_in = 1'b0;
            if (c == cssds_pkg::CH_STAR) begin
               cmt_in = cssds_pkg::CMT_BODY;
               plain  = 1'b0;
            end else begin
               keep_slash = 1'b1;
            end
         end
      end

      if (plain) begin
         if (c == cssds_pkg::CH_APOS || c == cssds_pkg::CH_QUOTE) begin
            quote_in = (c == cssds_pkg::CH_QUOTE) ? cssds_pkg::QUOTE_DOUBLE
                                                  : cssds_pkg::QUOTE_SINGLE;
            keep_c = 1'b1;
         end else if (c == cssds_pkg::CH_SLASH) begin
            if (req_ch.last_byte) begin
               keep_c = 1'b1;
            end else begin
               slash_in = 1'b1;
            end
         end else if (c == cssds_pkg::CH_LPAREN || c == cssds_pkg::CH_LBRACK ||
                      c == cssds_pkg::CH_LBRACE) begin
            if (depth_ff != '1) begin
               depth_in = depth_ff + DEPTH_BITS'(1);
            end else begin
               depth_sat = 1'b1;
            end
            keep_c = 1'b1;
         end else if (c == cssds_pkg::CH_RPAREN || c == cssds_pkg::CH_RBRACK ||
                      c == cssds_pkg::CH_RBRACE) begin
            if (depth_ff != '0) begin
               depth_in = depth_ff - DEPTH_BITS'(1);
            end
            keep_c = 1'b1;
         end else if (c == cssds_pkg::CH_SEMI && depth_ff == '0) begin
            end_seg = 1'b1;
         end else begin
            keep_c = 1'b1;
         end
      end
   end

   // apply the keeps in order, then the declaration and block ends
   always_comb begin
      seg_in  = seg_ff;
      bcnt_in = bcnt_ff;
      ovf_in  = ovf_ff | depth_sat;
      q_flags = '0;
      q_flags.byte_val = c;
      q_flush = '0;
      q_widx  = '0;

      if (keep_slash) begin
         q_flush = bcnt_in;
         bcnt_in = '0;
         q_flags.emit_slash = 1'b1;
         seg_in  = 1'b1;
      end

      if (keep_c) begin
         if (cssds_pkg::is_blank(c)) begin
            if (seg_in) begin
               if (bcnt_in < CW'(BLANK_DEPTH)) begin
                  q_flags.wr = 1'b1;
                  q_widx  = bcnt_in[AW-1:0];
                  bcnt_in = bcnt_in + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end else begin
            q_flush = q_flush | bcnt_in;
            bcnt_in = '0;
            q_flags.emit_byte = 1'b1;
            seg_in  = 1'b1;
         end
      end

      if (end_seg) begin
         q_flags.decl = seg_in;
         seg_in  = 1'b0;
         bcnt_in = '0;
      end

      if (req_ch.last_byte) begin
         q_flags.ovf   = ovf_in;
         q_flags.block = 1'b1;
         if (seg_in) begin
            q_flags.decl = 1'b1;
         end
         seg_in  = 1'b0;
         bcnt_in = '0;
         ovf_in  = 1'b0;
      end
   end

   assign q_push = accept && (q_flags.emit_slash || q_flags.emit_byte || q_flags.decl ||
                              q_flags.block || q_flags.wr);

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= cssds_pkg::QUOTE_NONE;
         esc_ff   <= 1'b0;
         cmt_ff   <= cssds_pkg::CMT_NONE;
         slash_ff <= 1'b0;
         depth_ff <= '0;
         seg_ff   <= 1'b0;
         bcnt_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (req_ch.last_byte) begin
            quote_ff <= cssds_pkg::QUOTE_NONE;
            esc_ff   <= 1'b0;
            cmt_ff   <= cssds_pkg::CMT_NONE;
            slash_ff <= 1'b0;
            depth_ff <= '0;
         end else begin
            quote_ff <= quote_in;
            esc_ff   <= esc_in;
            cmt_ff   <= cmt_in;
            slash_ff <= slash_in;
            depth_ff <= depth_in;
         end
         seg_ff  <= seg_in;
         bcnt_ff <= bcnt_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cssds_queue.sv
`default_nettype none

module cssds_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  push_ready,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0]                  slot_ff [cssds_pkg::QUEUE_DEPTH];
   logic [cssds_pkg::QPTR_W-1:0]      wptr_ff, rptr_ff;
   logic [cssds_pkg::QPTR_W:0]        count_ff;

   assign push_ready = count_ff != (cssds_pkg::QPTR_W + 1)'(cssds_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign rdata      = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + cssds_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + cssds_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (cssds_pkg::QPTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (cssds_pkg::QPTR_W + 1)'(1);
         end
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + (cssds_pkg::QPTR_W + 1)'(1))
      else $error("queue count lost a word");

endmodule

`default_nettype wire

>>> rtl/cssds_back.sv
`default_nettype none

module cssds_back #(
   parameter int BLANK_DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_valid,
   input  wire cssds_pkg::cmd_flags_type  q_flags,
   input  wire logic [$clog2(BLANK_DEPTH + 1)-1:0]                      q_flush,
   input  wire logic [((BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1)-1:0] q_widx,
   output logic                           q_pop,
   cssds_rsp_if.source                    rsp_ch
);

   localparam int CW = $clog2(BLANK_DEPTH + 1);
   localparam int AW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

   logic                     busy_ff, busy_in;
   cssds_pkg::cmd_flags_type flags_ff, flags_in;
   logic [CW-1:0]            flush_ff, flush_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [AW-1:0]            widx_ff, widx_in;
   logic [AW-1:0]            rd_addr;

   logic [7:0] blank_mem [BLANK_DEPTH];
   logic [7:0] rd_data_ff;

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic [1:0] kind_ff;
   logic       ovf_ff;
   logic       run_last_ff;

   logic       has_flush, pending, slot_free, emit, wr_en, done;
   logic [7:0] cur_byte;
   logic [1:0] cur_kind;
   logic       cur_ovf, more;

   assign has_flush = flush_ff != '0;
   assign pending   = has_flush || flags_ff.emit_slash || flags_ff.emit_byte ||
                      flags_ff.decl || flags_ff.block;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = busy_ff && pending && slot_free;
   // held blank is stored after this word's flush has read the buffer
   assign wr_en     = busy_ff && !pending && flags_ff.wr;
   assign done      = !busy_ff || (!pending && !flags_ff.wr);
   assign q_pop     = done && q_valid;

   always_comb begin
      busy_in  = busy_ff;
      flags_in = flags_ff;
      flush_in = flush_ff;
      idx_in   = idx_ff;
      widx_in  = widx_ff;
      cur_byte = 8'h00;
      cur_kind = cssds_pkg::KIND_DATA;
      cur_ovf  = 1'b0;
      more     = 1'b0;

      if (has_flush) begin
         cur_byte = rd_data_ff;
         more     = (flush_ff != CW'(1)) || flags_ff.emit_slash || flags_ff.emit_byte ||
                    flags_ff.decl || flags_ff.block;
      end else if (flags_ff.emit_slash) begin
         cur_byte = cssds_pkg::CH_SLASH;
         more     = flags_ff.emit_byte || flags_ff.decl || flags_ff.block;
      end else if (flags_ff.emit_byte) begin
         cur_byte = flags_ff.byte_val;
         more     = flags_ff.decl || flags_ff.block;
      end else if (flags_ff.decl) begin
         cur_kind = cssds_pkg::KIND_DECL;
         more     = flags_ff.block;
      end else begin
         cur_kind = cssds_pkg::KIND_BLOCK;
         cur_ovf  = flags_ff.ovf;
      end

      if (q_pop) begin
         busy_in  = 1'b1;
         flags_in = q_flags;
         flush_in = q_flush;
         widx_in  = q_widx;
         idx_in   = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (has_flush) begin
            flush_in = flush_ff - CW'(1);
            idx_in   = idx_ff + CW'(1);
         end else if (flags_ff.emit_slash) begin
            flags_in.emit_slash = 1'b0;
         end else if (flags_ff.emit_byte) begin
            flags_in.emit_byte = 1'b0;
         end else if (flags_ff.decl) begin
            flags_in.decl = 1'b0;
         end else begin
            flags_in.block = 1'b0;
         end
      end else if (wr_en) begin
         flags_in.wr = 1'b0;
      end
   end

   // read data always follows idx so the next flushed blank is ready
   assign rd_addr = (idx_in < CW'(BLANK_DEPTH)) ? idx_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blank_mem[widx_ff] <= flags_ff.byte_val;
      end
      rd_data_ff <= blank_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      flags_ff <= flags_in;
      flush_ff <= flush_in;
      idx_ff   <= idx_in;
      widx_ff  <= widx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         out_byte_ff <= cur_byte;
         kind_ff     <= cur_kind;
         ovf_ff      <= cur_ovf;
         run_last_ff <= !more;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.kind     = kind_ff;
   assign rsp_ch.overflow = ovf_ff;
   assign rsp_ch.run_last = run_last_ff;

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != cssds_pkg::KIND_DATA) |-> out_byte_ff == 8'h00)
      else $error("marker word carries a data byte");

   a_ovf_on_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != cssds_pkg::KIND_BLOCK) |-> !ovf_ff)
      else $error("overflow flag outside end of block");

   a_block_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == cssds_pkg::KIND_BLOCK) |-> run_last_ff)
      else $error("end of block not last of its run");

   a_flush_blank: assert property (@(posedge clock) disable iff (reset)
      (emit && has_flush) |=> (rsp_valid_ff && kind_ff == cssds_pkg::KIND_DATA &&
                               cssds_pkg::is_blank(out_byte_ff)))
      else $error("flushed byte is not a blank");

endmodule

`default_nettype wire

>>> rtl/css_declaration_splitter_unit.sv
// style declaration splitter
// req_ch takes one text byte per word, last_byte set on the final byte of a
// block. rsp_ch returns the trimmed declarations: kind data words with the
// kept bytes, a kind end-of-declaration word after each non-empty
// declaration and one end-of-block word carrying the overflow flag.
// run_last marks the final result word caused by one input byte.
// The front parses one byte per cycle while the queue has room and pushes
// a command into a four-entry queue; the back turns each command into
// result words, one per cycle while the receiver takes them, through an
// output register. The back takes each command from the queue, emits its
// result words (up to BLANK_DEPTH + 4) and then stores the byte when it is
// a trailing blank; bytes with no effect, such as comment text, push no
// command. Held trailing blanks sit in a BLANK_DEPTH-entry buffer with a
// registered read port and are replayed one per cycle while the output is
// not stalled. Reset clears parse state, queue and output register; the
// blank buffer keeps its contents, which are never read before rewritten.
// When the receiver stalls, the output word holds, the back waits, the
// queue fills and req_ch.ready drops once it is full.
`default_nettype none

module css_declaration_splitter_unit #(
   parameter int BLANK_DEPTH = 16,
   parameter int DEPTH_BITS  = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cssds_req_if.sink   req_ch,
   cssds_rsp_if.source rsp_ch
);

   localparam int CW      = $clog2(BLANK_DEPTH + 1);
   localparam int AW      = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
   localparam int FLAGS_W = $bits(cssds_pkg::cmd_flags_type);
   localparam int QW      = FLAGS_W + CW + AW;

   logic                     push, push_ready, pop, pop_valid;
   cssds_pkg::cmd_flags_type f_flags, b_flags;
   logic [CW-1:0]            f_flush, b_flush;
   logic [AW-1:0]            f_widx, b_widx;
   logic [QW-1:0]            q_wdata, q_rdata;

   cssds_front #(
      .BLANK_DEPTH(BLANK_DEPTH),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_ready(push_ready),
      .q_push (push),
      .q_flags(f_flags),
      .q_flush(f_flush),
      .q_widx (f_widx)
   );

   assign q_wdata = {f_flags, f_flush, f_widx};

   cssds_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (q_wdata),
      .push_ready(push_ready),
      .pop       (pop),
      .pop_valid (pop_valid),
      .rdata     (q_rdata)
   );

   assign b_flags = cssds_pkg::cmd_flags_type'(q_rdata[QW-1 -: FLAGS_W]);
   assign b_flush = q_rdata[AW +: CW];
   assign b_widx  = q_rdata[AW-1:0];

   cssds_back #(
      .BLANK_DEPTH(BLANK_DEPTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(pop_valid),
      .q_flags(b_flags),
      .q_flush(b_flush),
      .q_widx (b_widx),
      .q_pop  (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire
